// File: design/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELLS);

  // fixed field widths of the request and result
  localparam int OP_FW   = 2;
  localparam int CHAR_FW = 8;
  localparam int ROW_FW  = 5;
  localparam int COL_FW  = 7;
  localparam int CELL_FW = 16;
  localparam int ATTR_FW = 8;

  localparam logic [OP_FW-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_FW-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_FW-1:0] OP_READ  = 2'd2;

  localparam logic [CHAR_FW-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_FW-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_FW-1:0] ATTR_RESET   = 8'h0F;

  typedef struct packed {
    logic [OP_FW-1:0]   op;
    logic [CHAR_FW-1:0] char_code;
    logic [ROW_FW-1:0]  read_row;
    logic [COL_FW-1:0]  read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [CELL_FW-1:0] cell_value;
    logic [ROW_FW-1:0]  cursor_row;
    logic [COL_FW-1:0]  cursor_col;
  } tcw_out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch the accepted request
    logic exec_put;    // write character at cursor, advance cursor
    logic exec_nl;     // newline cursor move
    logic exec_clear;  // home cursor, arm full-screen blank sweep
    logic value_load;  // take RAM read data as result value
    logic value_clr;   // result value is zero
    logic sweep_step;  // write one blank cell, step sweep address
    logic blank_rst;   // blank uses the reset attribute
    logic out_load;    // load result register
    logic out_fast;    // result from next cursor with zero value
  } tcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_FW-1:0] op;
    logic             newline;
    logic             scroll;
    logic             read_ok;
    logic             sweep_last;
    logic             out_free;
  } tcw_stat_t;

endpackage
`default_nettype wire

// File: design/tcw_ram.sv
`default_nettype none
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/tcw_ctrl.sv
`default_nettype none
module tcw_ctrl
  import tcw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire tcw_stat_t stat,
  output tcw_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_SWEEP = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_RDATA = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   init_r, init_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      init_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      init_r  <= init_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    init_nxt  = init_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.blank_rst  = init_r;
        if (stat.sweep_last) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.value_clr = 1'b1;
        state_nxt     = S_DONE;
        case (stat.op)
          OP_PUT: begin
            cmd.exec_nl  = stat.newline;
            cmd.exec_put = !stat.newline;
            if (stat.scroll) begin
              state_nxt = S_SWEEP;
            end
          end
          OP_CLEAR: begin
            cmd.exec_clear = 1'b1;
            state_nxt      = S_SWEEP;
          end
          OP_READ: begin
            // RAM read address is presented this cycle
            if (stat.read_ok) begin
              state_nxt = S_RDATA;
            end
          end
          default: ;
        endcase
        // short requests finish here when the result slot is free
        if (state_nxt == S_DONE && stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_fast = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RDATA: begin
        cmd.value_load = 1'b1;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/tcw_dp.sv
`default_nettype none
module tcw_dp
  import tcw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [ATTR_FW-1:0]  cfg_wdata,
  input  wire tcw_in_t             in_data,
  input  wire tcw_cmd_t            cmd,
  output tcw_stat_t                stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tcw_out_t                 out_data
);

  // rows are kept as a ring: logical row r lives at physical row (r + top) mod ROWS
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    logic [ROW_W:0] phys;
    sum  = {1'b0, row} + {1'b0, top};
    phys = (sum >= (ROW_W+1)'(ROWS)) ? sum - (ROW_W+1)'(ROWS) : sum;
    return ADDR_W'(ADDR_W'(phys) * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  endfunction

  function automatic logic [ROW_W-1:0] bottom_top_wrap(input logic [ROW_W-1:0] t);
    return (t == ROW_W'(ROWS - 1)) ? '0 : t + 1'b1;
  endfunction

  tcw_in_t             item_r;
  logic [ATTR_FW-1:0]  attr_r;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    top_r, top_nxt;
  logic [ADDR_W-1:0]   sweep_addr_r, sweep_addr_nxt;
  logic [ADDR_W-1:0]   sweep_last_r, sweep_last_nxt;
  logic [CELL_FW-1:0]  value_r;
  logic                out_valid_r;
  tcw_out_t            out_r;

  logic                newline, wrap, bottom, adv_row;
  logic [ROW_W-1:0]    top_inc;
  logic [ADDR_W-1:0]   cur_addr, rd_addr, scroll_start;
  logic [CELL_FW-1:0]  blank, rdata;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_FW-1:0]  ram_wdata;

  assign newline      = (item_r.char_code == NEWLINE_CHAR);
  assign wrap         = (col_r == COL_W'(COLUMNS - 1));
  assign bottom       = (row_r == ROW_W'(ROWS - 1));
  assign top_inc      = bottom_top_wrap(top_r);
  assign cur_addr     = cell_addr(row_r, col_r, top_r);
  assign rd_addr      = cell_addr(ROW_W'(item_r.read_row), COL_W'(item_r.read_col), top_r);
  assign scroll_start = cell_addr('0, '0, top_r);
  assign blank        = {(cmd.blank_rst ? ATTR_RESET : attr_r), BLANK_CHAR};

  assign stat.op         = item_r.op;
  assign stat.newline    = newline;
  assign stat.scroll     = bottom && (newline || wrap);
  assign stat.read_ok    = (32'(item_r.read_row) < ROWS) && (32'(item_r.read_col) < COLUMNS);
  assign stat.sweep_last = (sweep_addr_r == sweep_last_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    row_nxt        = row_r;
    col_nxt        = col_r;
    top_nxt        = top_r;
    sweep_addr_nxt = sweep_addr_r;
    sweep_last_nxt = sweep_last_r;
    adv_row        = 1'b0;
    if (cmd.exec_put) begin
      if (wrap) begin
        col_nxt = '0;
        adv_row = 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cmd.exec_nl) begin
      col_nxt = '0;
      adv_row = 1'b1;
    end
    if (adv_row) begin
      if (bottom) begin
        // old top row becomes the new bottom row; blank it
        top_nxt        = top_inc;
        sweep_addr_nxt = scroll_start;
        sweep_last_nxt = scroll_start + ADDR_W'(COLUMNS - 1);
      end else begin
        row_nxt = row_r + 1'b1;
      end
    end
    if (cmd.exec_clear) begin
      row_nxt        = '0;
      col_nxt        = '0;
      top_nxt        = '0;
      sweep_addr_nxt = '0;
      sweep_last_nxt = ADDR_W'(CELLS - 1);
    end
    if (cmd.sweep_step) begin
      sweep_addr_nxt = sweep_addr_r + 1'b1;
    end
  end

  always_comb begin
    ram_we    = cmd.exec_put || cmd.sweep_step;
    ram_waddr = cmd.sweep_step ? sweep_addr_r : cur_addr;
    ram_wdata = cmd.sweep_step ? blank : {attr_r, item_r.char_code};
  end

  tcw_ram #(
    .WIDTH (CELL_FW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r       <= ATTR_RESET;
      row_r        <= '0;
      col_r        <= '0;
      top_r        <= '0;
      sweep_addr_r <= '0;
      sweep_last_r <= ADDR_W'(CELLS - 1);
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      top_r        <= top_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_last_r <= sweep_last_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.value_clr) begin
      value_r <= '0;
    end else if (cmd.value_load) begin
      value_r <= rdata;
    end
    if (cmd.out_load) begin
      if (cmd.out_fast) begin
        out_r.cell_value <= '0;
        out_r.cursor_row <= ROW_FW'(row_nxt);
        out_r.cursor_col <= COL_FW'(col_nxt);
      end else begin
        out_r.cell_value <= value_r;
        out_r.cursor_row <= ROW_FW'(row_r);
        out_r.cursor_col <= COL_FW'(col_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: design/text_console_writer_top.sv
`default_nettype none
// Text console engine: a ROWS x COLUMNS grid of 16-bit cells (attribute over character)
// in one single-port-write RAM, plus a cursor. Rows are addressed as a ring, so a
// scroll only moves the top-row pointer and blanks one row. A put or an unused or
// out-of-range request completes in the execute state when the result slot is
// free, a read goes through the registered RAM read, and a put that scrolls or a
// clear runs a blank sweep (one blank cell written per cycle) over one row or the
// whole RAM. After reset the block blanks the whole RAM, one cell per cycle, before
// in_ready rises; attribute writes are taken at any time. The result register lets
// a new request be accepted while the previous result waits on out_ready.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [ATTR_FW-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tcw_in_t            in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tcw_out_t                out_data
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
